### rtl/core/rpa_pkg.sv
// Package for the rainbow pixel animator: the pixel record, the command codes,
// the control group of the pixel store and the color wheel function.
// No dependencies; every other file of the block imports it.
package rpa_pkg;

    // Command codes of the input channel.
    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_LOAD = 1'b1
    } cmd_t;

    // At most this many results leave the block per tick.
    localparam int RESULT_LIMIT = 16;
    localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

    // Color wheel constants.
    localparam logic [7:0] WHEEL_FULL       = 8'd255;
    localparam logic [7:0] WHEEL_THIRD      = 8'd85;
    localparam logic [7:0] WHEEL_TWO_THIRDS = 8'd170;

    // One pixel's stored state.
    typedef struct packed {
        logic [31:0] due;
        logic [7:0]  interval;
        logic [7:0]  hue;
    } pixel_t;

    // Port controls of the pixel store.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } store_ctl_t;

    // One color from the wheel.
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // Three times an 8-bit value below 85 fits in 8 bits.
    function automatic logic [7:0] times_three(input logic [7:0] v);
        logic [9:0] t;
        t = {2'b00, v} + {1'b0, v, 1'b0};
        return t[7:0];
    endfunction

    // Map a hue position onto a red, green and blue intensity.
    function automatic rgb_t wheel_rgb(input logic [7:0] hue);
        logic [7:0] w;
        logic [7:0] w3;
        rgb_t       c;
        w = WHEEL_FULL - hue;
        if (w < WHEEL_THIRD)
        begin
            w3  = times_three(w);
            c.r = WHEEL_FULL - w3;
            c.g = 8'd0;
            c.b = w3;
        end
        else if (w < WHEEL_TWO_THIRDS)
        begin
            w3  = times_three(w - WHEEL_THIRD);
            c.r = 8'd0;
            c.g = w3;
            c.b = WHEEL_FULL - w3;
        end
        else
        begin
            w3  = times_three(w - WHEEL_TWO_THIRDS);
            c.r = w3;
            c.g = WHEEL_FULL - w3;
            c.b = 8'd0;
        end
        return c;
    endfunction

endpackage

### rtl/core/rpa_pixel_store.sv
// Pixel store: one memory of pixel records with a registered read port and
// one valid bit per entry so that unwritten due times read as zero.
// Depends on rpa_pkg.
module rpa_pixel_store #(
    parameter int NUM_PIXELS = 16,
    parameter int IDX_W      = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rpa_pkg::store_ctl_t ctl,
    input  logic [IDX_W-1:0]    wr_addr,
    input  rpa_pkg::pixel_t     wr_data,
    input  logic [IDX_W-1:0]    rd_addr,
    output rpa_pkg::pixel_t     rd_data
);
    import rpa_pkg::*;

    pixel_t                mem [NUM_PIXELS];
    logic [NUM_PIXELS-1:0] valid_reg;
    pixel_t                rd_raw_reg;
    logic                  rd_valid_reg;

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    // Written flags; reset makes every due time read as zero at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // An entry never written reports a zero due time.
    always_comb
    begin
        rd_data     = rd_raw_reg;
        rd_data.due = rd_valid_reg ? rd_raw_reg.due : 32'd0;
    end

endmodule

### rtl/core/rpa_step_unit.sv
// Shared step unit: one 32-bit due compare and one 32-bit add, applied to
// each pixel in turn by the sequencer. Depends on rpa_pkg.
module rpa_step_unit (
    input  logic [31:0]     now,
    input  rpa_pkg::pixel_t cur,
    output rpa_pkg::pixel_t nxt
);
    import rpa_pkg::*;

    logic due_hit;

    // A due pixel steps its hue and is rescheduled one interval later.
    always_comb
    begin
        due_hit = (now >= cur.due);
        nxt     = cur;
        if (due_hit)
        begin
            nxt.due = now + {24'd0, cur.interval};
            nxt.hue = cur.hue + 8'd1;
        end
    end

endmodule

### rtl/core/rainbow_pixel_animator_core.sv
// Rainbow pixel animator, top level.
// Input channel (in_valid / in_stall): a load writes one pixel's interval and
// starting hue and clears its due time; it gives no result.
// A tick carries the time in milliseconds. The sequencer then visits pixels
// FIRST_ANIMATED to NUM_PIXELS-1 in order through one shared compare-and-add
// unit: a due pixel steps its hue and is rescheduled, and the first sixteen
// visited pixels each send one color result, the final one with last_of_run.
// Each pixel passes through a memory read state, then an update and write back
// state, so in_stall stays high until the sweep over the animated pixels ends;
// the first result is registered from the update state of the first pixel. The
// registered read of the pixel memory is why each pixel needs the read state.
// Output channel (out_valid / out_stall): results sit in an output register.
// While the receiver stalls a waiting result, the sequencer holds a pixel that
// has a result to send and resumes when the output register frees; nothing is lost or repeated.
// Reset is asynchronous and active low: it clears the sequencer, the output
// valid and the written flags of the memory, so every due time reads as zero
// at once and no clearing pass is needed.
// Depends on rpa_pkg, rpa_pixel_store and rpa_step_unit.
module rainbow_pixel_animator_core #(
    parameter int NUM_PIXELS     = 16,
    parameter int FIRST_ANIMATED = 0
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [31:0] tick_time,
    input  logic [3:0]  load_index,
    input  logic [7:0]  load_interval,
    input  logic [7:0]  load_hue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  out_pixel_index,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        last_of_run
);
    import rpa_pkg::*;

    localparam int              IDX_W     = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
    localparam bit              ANY_ANIM  = (FIRST_ANIMATED < NUM_PIXELS);
    localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(FIRST_ANIMATED);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_PIXELS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_UPDATE
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      now_reg, now_next;
    logic             out_valid_reg, out_valid_next;
    logic [3:0]       out_index_reg;
    rgb_t             out_rgb_reg;
    logic             out_last_reg;

    store_ctl_t       ctl;
    logic [IDX_W-1:0] wr_addr;
    pixel_t           wr_data;
    pixel_t           rd_data;
    pixel_t           step_data;
    rgb_t             step_rgb;

    logic             accept;
    logic             load_ok;
    logic             emit;
    logic             out_free;
    logic             advance;
    logic             load_out;

    // Pixel memory and the shared step unit.
    rpa_pixel_store #(
        .NUM_PIXELS(NUM_PIXELS),
        .IDX_W     (IDX_W)
    ) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(idx_reg),
        .rd_data(rd_data)
    );

    rpa_step_unit u_step (
        .now(now_reg),
        .cur(rd_data),
        .nxt(step_data)
    );

    assign step_rgb = wheel_rgb(step_data.hue);

    // Handshake and step conditions.
    always_comb
    begin
        in_stall = (state_reg != S_IDLE);
        accept   = in_valid && !in_stall;
        load_ok  = accept && (command == CMD_LOAD) && (32'(load_index) < NUM_PIXELS);
        emit     = (cnt_reg < CNT_W'(RESULT_LIMIT));
        out_free = !out_valid_reg || !out_stall;
        advance  = (state_reg == S_UPDATE) && (!emit || out_free);
        load_out = advance && emit;
    end

    // Memory port control: loads from idle, write back from the update step.
    always_comb
    begin
        ctl.wr_en = load_ok || advance;
        ctl.rd_en = (state_reg == S_READ);
        if (advance)
        begin
            wr_addr = idx_reg;
            wr_data = step_data;
        end
        else
        begin
            wr_addr          = IDX_W'(load_index);
            wr_data.due      = 32'd0;
            wr_data.interval = load_interval;
            wr_data.hue      = load_hue;
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        now_next       = now_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (command == CMD_TICK) && ANY_ANIM)
                begin
                    now_next   = tick_time;
                    idx_next   = FIRST_IDX;
                    cnt_next   = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (advance)
                begin
                    if (emit)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            now_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            out_rgb_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            now_reg       <= now_next;
            out_valid_reg <= out_valid_next;
            if (load_out)
            begin
                out_index_reg <= 4'(idx_reg);
                out_rgb_reg   <= step_rgb;
                out_last_reg  <= (cnt_reg == CNT_W'(RESULT_LIMIT - 1)) ||
                                 (idx_reg == LAST_IDX);
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_pixel_index = out_index_reg;
    assign red             = out_rgb_reg.r;
    assign green           = out_rgb_reg.g;
    assign blue            = out_rgb_reg.b;
    assign last_of_run     = out_last_reg;

    // A new result is only ever produced by the update step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_UPDATE) |=> !$rose(out_valid_reg))
        else $error("result appeared outside the update step");

    // No more results per tick than the limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(RESULT_LIMIT))
        else $error("result count passed the limit");

    // A tick transfer with animated pixels starts the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (command == CMD_TICK) && ANY_ANIM) |=> (state_reg == S_READ))
        else $error("tick did not start the pixel sweep");

    // The sweep ends only after the last pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_UPDATE) && (state_next == S_IDLE)) |-> (idx_reg == LAST_IDX))
        else $error("pixel sweep ended early");

endmodule
